// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TLCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TLCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tlca_pkg.sv =====
package tlca_pkg;

  localparam int NODE_W = 10;
  localparam int DEP_W  = 10;
  localparam int HOP_W  = 11;
  localparam int WGT_W  = 32;
  localparam int DIST_W = 48;
  localparam int NODE_SPAN = 1 << NODE_W;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_LOAD  = 2'd1;
  localparam logic [1:0] STAT_BAD_QUERY = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [NODE_W-1:0] probe_node;
    logic              is_root;
    logic [WGT_W-1:0]  edge_weight;
  } tlca_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] lca_node;
    logic [HOP_W-1:0]  hop_distance;
    logic [DIST_W-1:0] weighted_distance;
    logic              probe_on_path;
  } tlca_out_t;

  // Item plus range checks done at the front.
  typedef struct packed {
    tlca_in_t item;
    logic     a_ok;
    logic     b_ok;
    logic     p_ok;
  } tlca_job_t;

  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] node;
  } tlca_anc_t;

  typedef struct packed {
    logic              loaded;
    logic [DEP_W-1:0]  depth;
    logic [DIST_W-1:0] rdist;
  } tlca_info_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_LD_A, ST_LD_B, ST_LD_DEC, ST_LD_ANC, ST_LD_ANC_CHK,
    ST_Q_U, ST_Q_V, ST_Q_P, ST_Q_DEC,
    ST_SETUP, ST_LIFT, ST_LIFT_CHK, ST_CMP, ST_JUMP, ST_JUMP_CHK,
    ST_FIN, ST_FIN_CHK, ST_LDEP, ST_LDEP_CHK, ST_SUM, ST_EMIT
  } tlca_state_t;

endpackage

// ===== hdl/tlca_front.sv =====
module tlca_front #(
  parameter int MAX_NODES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tlca_pkg::tlca_in_t  in_data,
  input  logic                hold,
  output logic                job_valid,
  output tlca_pkg::tlca_job_t job,
  input  logic                job_pop
);
  import tlca_pkg::*;

  tlca_job_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  tlca_job_t  cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.item = in_data;
    cls.a_ok = 32'(in_data.first_node)  < 32'(MAX_NODES);
    cls.b_ok = 32'(in_data.second_node) < 32'(MAX_NODES);
    cls.p_ok = 32'(in_data.probe_node)  < 32'(MAX_NODES);
  end

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls;
  end

endmodule

// ===== hdl/tlca_res_q.sv =====
module tlca_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  tlca_pkg::tlca_out_t res_data,
  output logic                res_full,
  output logic                out_empty,
  input  logic                out_pop,
  output tlca_pkg::tlca_out_t out_data
);
  import tlca_pkg::*;

  tlca_out_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign res_full  = cnt_r == 2'd2;
  assign out_empty = cnt_r == 2'd0;
  assign out_data  = q_r[rp_r];
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= res_data;
  end

endmodule

// ===== hdl/tlca_engine.sv =====
module tlca_engine #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  tlca_pkg::tlca_job_t job,
  output logic                job_pop,
  input  logic                res_full,
  output logic                res_push,
  output tlca_pkg::tlca_out_t res_data,
  output logic                clearing
);
  import tlca_pkg::*;

  localparam int DEPTH     = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam int AW        = $clog2(DEPTH);
  localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_DEPTH = LIFT_LEVELS * DEPTH;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);
  localparam logic [LW-1:0] K_TOP = LW'(LIFT_LEVELS - 1);

  function automatic logic [ANC_AW-1:0] anc_idx(input logic [LW-1:0] k,
                                                input logic [AW-1:0] n);
    return ANC_AW'(k) * ANC_AW'(DEPTH) + ANC_AW'(n);
  endfunction

  tlca_anc_t  anc_mem [ANC_DEPTH];
  tlca_info_t node_mem [DEPTH];

  tlca_anc_t   anc_qa_r, anc_qb_r;
  tlca_info_t  node_q_r;
  logic [ANC_AW-1:0] anc_ra, anc_rb, anc_waddr;
  logic        anc_we;
  tlca_anc_t   anc_wdata;
  logic [AW-1:0] node_ra, node_waddr;
  logic        node_we;
  tlca_info_t  node_wdata;

  tlca_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          root_present_r;

  tlca_in_t          it_r;
  logic              la_r, lb_r;
  logic [DEP_W-1:0]  du_r, dv_r, dq_r, diff_r;
  logic [DIST_W-1:0] distu_r, distv_r, wa_r, wb_r;
  logic [AW-1:0]     u_r, v_r, l_r, lca_r;
  logic [LW-1:0]     k_r;
  logic [1:0]        pass_r;
  logic [HOP_W-1:0]  h_r, h1_r;
  logic              probe_r;
  tlca_anc_t         cur_r;
  tlca_out_t         res_r;

  logic [AW-1:0]     a_n, b_n, p_n, nx, ny;
  logic [DEP_W-1:0]  sx, sy;
  logic [HOP_W:0]    hsum;
  logic [16:0]       step;
  logic              ld_bad, jdiff;
  logic [DIST_W:0]   dsum, wsum;

  assign a_n = AW'(it_r.first_node);
  assign b_n = AW'(it_r.second_node);
  assign p_n = AW'(it_r.probe_node);
  assign step = 17'(1) << k_r;
  assign clearing = state_r == ST_CLR;
  assign res_data = res_r;

  always_comb begin
    unique case (pass_r)
      2'd0: begin sx = du_r; sy = dv_r; nx = a_n; ny = b_n; end
      2'd1: begin sx = du_r; sy = dq_r; nx = a_n; ny = p_n; end
      default: begin sx = dq_r; sy = dv_r; nx = p_n; ny = b_n; end
    endcase
  end

  assign hsum   = (HOP_W+1)'(sx) + (HOP_W+1)'(sy) - (HOP_W+1)'({node_q_r.depth, 1'b0});
  assign ld_bad = la_r || (it_r.is_root ? root_present_r : !node_q_r.loaded);
  assign jdiff  = anc_qa_r.vld && anc_qb_r.vld && (anc_qa_r.node != anc_qb_r.node);
  assign dsum   = (DIST_W+1)'(node_q_r.rdist) + (DIST_W+1)'(it_r.edge_weight);
  assign wsum   = (DIST_W+1)'(wa_r) + (DIST_W+1)'(wb_r);

  // Memories: one write port, registered reads.
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    anc_qa_r <= anc_mem[anc_ra];
    anc_qb_r <= anc_mem[anc_rb];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_q_r <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    job_pop    = 1'b0;
    res_push   = 1'b0;
    anc_ra     = anc_idx(k_r, u_r);
    anc_rb     = anc_idx(k_r, v_r);
    anc_we     = 1'b0;
    anc_waddr  = anc_idx(k_r, a_n);
    anc_wdata  = cur_r;
    node_ra    = a_n;
    node_we    = 1'b0;
    node_waddr = a_n;
    node_wdata = '0;
    unique case (state_r)
      ST_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_cnt_r;
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.item.req_type == REQ_LOAD) begin
            if (!job.a_ok || (!job.item.is_root && !job.b_ok)) state_nxt = ST_EMIT;
            else state_nxt = ST_LD_A;
          end else begin
            if (!(job.a_ok && job.b_ok && job.p_ok)) state_nxt = ST_EMIT;
            else state_nxt = ST_Q_U;
          end
        end
      end
      ST_LD_A: state_nxt = ST_LD_B;
      ST_LD_B: begin
        node_ra   = b_n;
        state_nxt = ST_LD_DEC;
      end
      ST_LD_DEC: begin
        if (ld_bad) begin
          state_nxt = ST_EMIT;
        end else begin
          node_we           = 1'b1;
          node_wdata.loaded = 1'b1;
          if (!it_r.is_root) begin
            node_wdata.depth = node_q_r.depth + 1'b1;
            node_wdata.rdist = dsum[DIST_W] ? DIST_MAX : dsum[DIST_W-1:0];
          end
          state_nxt = ST_LD_ANC;
        end
      end
      ST_LD_ANC: begin
        anc_we = 1'b1;
        anc_ra = anc_idx(k_r, AW'(cur_r.node));
        if (k_r == K_TOP) state_nxt = ST_EMIT;
        else state_nxt = ST_LD_ANC_CHK;
      end
      ST_LD_ANC_CHK: state_nxt = ST_LD_ANC;
      ST_Q_U: state_nxt = ST_Q_V;
      ST_Q_V: begin
        node_ra   = b_n;
        state_nxt = ST_Q_P;
      end
      ST_Q_P: begin
        node_ra   = p_n;
        state_nxt = ST_Q_DEC;
      end
      ST_Q_DEC: begin
        if (la_r && lb_r && node_q_r.loaded) state_nxt = ST_SETUP;
        else state_nxt = ST_EMIT;
      end
      ST_SETUP: state_nxt = ST_LIFT;
      ST_LIFT: begin
        if (17'(diff_r) >= step) state_nxt = ST_LIFT_CHK;
        else if (k_r == '0) state_nxt = ST_CMP;
      end
      ST_LIFT_CHK: begin
        if (!anc_qa_r.vld && k_r == '0) state_nxt = ST_CMP;
        else state_nxt = ST_LIFT;
      end
      ST_CMP: begin
        if (u_r == v_r) state_nxt = ST_LDEP;
        else state_nxt = ST_JUMP;
      end
      ST_JUMP: state_nxt = ST_JUMP_CHK;
      ST_JUMP_CHK: begin
        if ((jdiff && k_r == K_TOP) || k_r != '0) state_nxt = ST_JUMP;
        else state_nxt = ST_FIN;
      end
      ST_FIN: begin
        anc_ra    = anc_idx('0, u_r);
        state_nxt = ST_FIN_CHK;
      end
      ST_FIN_CHK: state_nxt = ST_LDEP;
      ST_LDEP: begin
        node_ra   = l_r;
        state_nxt = ST_LDEP_CHK;
      end
      ST_LDEP_CHK: begin
        if (pass_r == 2'd2) state_nxt = ST_SUM;
        else state_nxt = ST_SETUP;
      end
      ST_SUM: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r      <= '0;
      root_present_r <= 1'b0;
    end else begin
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_LD_DEC && !ld_bad && it_r.is_root) root_present_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        it_r  <= job.item;
        res_r <= '0;
        if (job.item.req_type == REQ_LOAD) res_r.status <= STAT_BAD_LOAD;
        else res_r.status <= STAT_BAD_QUERY;
      end
      ST_LD_B: la_r <= node_q_r.loaded;
      ST_LD_DEC: begin
        k_r <= '0;
        if (it_r.is_root) cur_r <= '0;
        else cur_r <= '{vld: 1'b1, node: it_r.second_node};
        if (!ld_bad) res_r.status <= STAT_OK;
      end
      ST_LD_ANC_CHK: begin
        if (cur_r.vld && anc_qa_r.vld) cur_r <= anc_qa_r;
        else cur_r <= '0;
        k_r <= k_r + 1'b1;
      end
      ST_Q_V: begin
        la_r    <= node_q_r.loaded;
        du_r    <= node_q_r.depth;
        distu_r <= node_q_r.rdist;
      end
      ST_Q_P: begin
        lb_r    <= node_q_r.loaded;
        dv_r    <= node_q_r.depth;
        distv_r <= node_q_r.rdist;
      end
      ST_Q_DEC: begin
        dq_r   <= node_q_r.depth;
        pass_r <= 2'd0;
      end
      ST_SETUP: begin
        k_r <= K_TOP;
        // Lift the deeper node of the pair.
        if (sx < sy) begin
          u_r <= ny; v_r <= nx; diff_r <= sy - sx;
        end else begin
          u_r <= nx; v_r <= ny; diff_r <= sx - sy;
        end
      end
      ST_LIFT: begin
        if (17'(diff_r) < step && k_r != '0) k_r <= k_r - 1'b1;
      end
      ST_LIFT_CHK: begin
        if (anc_qa_r.vld) begin
          u_r    <= AW'(anc_qa_r.node);
          diff_r <= diff_r - DEP_W'(step);
        end else if (k_r != '0) begin
          k_r <= k_r - 1'b1;
        end
      end
      ST_CMP: begin
        l_r <= u_r;
        k_r <= K_TOP;
      end
      ST_JUMP_CHK: begin
        if (jdiff) begin
          u_r <= AW'(anc_qa_r.node);
          v_r <= AW'(anc_qb_r.node);
        end
        // Top level repeats while the jumps still differ.
        if (!(jdiff && k_r == K_TOP) && k_r != '0) k_r <= k_r - 1'b1;
      end
      ST_FIN_CHK: l_r <= anc_qa_r.vld ? AW'(anc_qa_r.node) : u_r;
      ST_LDEP_CHK: begin
        pass_r <= pass_r + 1'b1;
        unique case (pass_r)
          2'd0: begin
            h_r   <= HOP_W'(hsum);
            lca_r <= l_r;
            wa_r  <= distu_r - node_q_r.rdist;
            wb_r  <= distv_r - node_q_r.rdist;
          end
          2'd1: h1_r <= HOP_W'(hsum);
          default: probe_r <= ((HOP_W+1)'(h1_r) + hsum) == (HOP_W+1)'(h_r);
        endcase
      end
      ST_SUM: begin
        res_r.status            <= STAT_OK;
        res_r.lca_node          <= NODE_W'(lca_r);
        res_r.hop_distance      <= h_r;
        res_r.weighted_distance <= wsum[DIST_W] ? DIST_MAX : wsum[DIST_W-1:0];
        res_r.probe_on_path     <= probe_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/tree_lca_binary_lifting_core.sv =====
// Load: read both nodes, check, then write the node entry and each ancestor level; bad loads end at
// pickup or after the check. Query: read three nodes, then three LCA searches; bad queries end at
// pickup or after the reads. A search lifts the deeper node, then, if the pair still differs, steps
// through every jump level. One item at a time: no new job is popped until the result is pushed.
// A full result queue stalls the engine; a 2-entry queue on each side decouples neighbors.
// Sync active-low reset clears queues and root flag; a min(MAX_NODES,1024)-node clear holds in_full.
`include "assert_macros.svh"

module tree_lca_binary_lifting_core #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tlca_pkg::tlca_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output tlca_pkg::tlca_out_t out_data
);
  import tlca_pkg::*;

  logic      job_valid, job_pop, res_push, res_full, clearing;
  tlca_job_t job;
  tlca_out_t res_data;

  tlca_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .hold      (clearing),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  tlca_engine #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .clearing  (clearing)
  );

  tlca_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `TLCA_ASSERT_ALWAYS(a_clear_blocks_input, clearing |-> in_full, "input open during clearing")
  `TLCA_ASSERT(a_no_push_when_full, res_push |-> !res_full, "result pushed into full queue")
  `TLCA_ASSERT(a_pop_needs_job, job_pop |-> job_valid, "engine took a job from empty queue")
  `TLCA_ASSERT(a_result_from_push, $fell(out_empty) |-> $past(res_push), "result appeared unpushed")

endmodule
